### design/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// property whose consequence is checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bzc_pkg.sv
// types, constants and register codes for the cubic bezier evaluator
package bzc_pkg;

	localparam int COORD_W   = 16;
	localparam int FRAC_W    = 16;
	localparam int PARAM_W   = FRAC_W + 1;
	localparam int NUM_PTS   = 4;
	localparam int LANE_W    = COORD_W + 4;
	localparam int PROD_W    = LANE_W + PARAM_W + 2;
	localparam int OUT_W     = 24;
	localparam int CFG_IDX_W = 4;
	localparam int LVL_W     = 2;

	localparam logic [PARAM_W-1:0] T_ONE = PARAM_W'(1) << FRAC_W;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P0_X = 4'd0,
		REG_P0_Y = 4'd1,
		REG_P1_X = 4'd2,
		REG_P1_Y = 4'd3,
		REG_P2_X = 4'd4,
		REG_P2_Y = 4'd5,
		REG_P3_X = 4'd6,
		REG_P3_Y = 4'd7
	} reg_idx_t;

	// derivative order codes
	typedef enum logic [1:0] {
		ORD_POINT  = 2'd0,
		ORD_FIRST  = 2'd1,
		ORD_SECOND = 2'd2,
		ORD_THIRD  = 2'd3
	} order_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [NUM_PTS-1:0] coords_t;
	typedef logic signed [LANE_W-1:0] lane_t;
	typedef lane_t [NUM_PTS-1:0] lanes_t;

	// item moving down the chain of cells
	typedef struct packed {
		lanes_t lx;
		lanes_t ly;
		logic [PARAM_W-1:0] t;
		order_t order;
		logic [LVL_W-1:0] levels;
	} work_t;

endpackage

### design/bzc_front.sv
// entry stage: clamps t and forms forward differences of the control points
module bzc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bzc_pkg::PARAM_W-1:0]     param_t,
	input  logic [1:0]                      deriv_order,
	input  bzc_pkg::coords_t                px,
	input  bzc_pkg::coords_t                py,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bzc_pkg::work_t                  out_item
);

	logic           valid_s1;
	bzc_pkg::work_t item_s1;
	bzc_pkg::work_t item_d;
	bzc_pkg::order_t order_d;

	// order-th forward difference of four points, unused lanes zero
	function automatic bzc_pkg::lanes_t diff_lanes(bzc_pkg::coords_t p, bzc_pkg::order_t o);
		bzc_pkg::lanes_t d0;
		bzc_pkg::lanes_t d1;
		bzc_pkg::lanes_t d2;
		bzc_pkg::lanes_t d3;
		bzc_pkg::lanes_t r;
		for (int i = 0; i < bzc_pkg::NUM_PTS; i++) begin
			d0[i] = bzc_pkg::LANE_W'(signed'(p[i]));
		end
		d1 = '0;
		d2 = '0;
		d3 = '0;
		for (int i = 0; i < 3; i++) begin
			d1[i] = d0[i+1] - d0[i];
		end
		for (int i = 0; i < 2; i++) begin
			d2[i] = d1[i+1] - d1[i];
		end
		d3[0] = d2[1] - d2[0];
		unique case (o)
			bzc_pkg::ORD_POINT:  r = d0;
			bzc_pkg::ORD_FIRST:  r = d1;
			bzc_pkg::ORD_SECOND: r = d2;
			bzc_pkg::ORD_THIRD:  r = d3;
			default:             r = d0;
		endcase
		return r;
	endfunction

	// next item: clamp t to one, pick difference level, count lerp levels
	always_comb begin
		order_d = bzc_pkg::order_t'(deriv_order);
		item_d.lx = diff_lanes(px, order_d);
		item_d.ly = diff_lanes(py, order_d);
		item_d.t = (param_t > bzc_pkg::T_ONE) ? bzc_pkg::T_ONE : param_t;
		item_d.order = order_d;
		item_d.levels = bzc_pkg::LVL_W'(3) - bzc_pkg::LVL_W'(deriv_order);
	end

	assign in_ready = !valid_s1 || out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

### design/bzc_cell.sv
// one de casteljau level: lerps neighboring lanes or passes the item through
module bzc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bzc_pkg::work_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output bzc_pkg::work_t out_item
);

	logic           valid_q;
	bzc_pkg::work_t item_q;
	bzc_pkg::work_t item_d;

	// a + floor(((b - a) * t + half) / 2^frac), stays between a and b
	function automatic logic signed [bzc_pkg::LANE_W-1:0] lerp(
		logic signed [bzc_pkg::LANE_W-1:0] a,
		logic signed [bzc_pkg::LANE_W-1:0] b,
		logic [bzc_pkg::PARAM_W-1:0]       t
	);
		logic signed [bzc_pkg::LANE_W:0]   d;
		logic signed [bzc_pkg::PROD_W-1:0] p;
		d = (bzc_pkg::LANE_W+1)'(b) - (bzc_pkg::LANE_W+1)'(a);
		p = d * signed'({1'b0, t});
		p = p + signed'(bzc_pkg::ROUND_HALF);
		return a + bzc_pkg::LANE_W'(p >>> bzc_pkg::FRAC_W);
	endfunction

	// one interpolation level while levels remain
	always_comb begin
		item_d = in_item;
		if (in_item.levels != '0) begin
			for (int i = 0; i < bzc_pkg::NUM_PTS - 1; i++) begin
				item_d.lx[i] = lerp(in_item.lx[i], in_item.lx[i+1], in_item.t);
				item_d.ly[i] = lerp(in_item.ly[i], in_item.ly[i+1], in_item.t);
			end
			item_d.levels = in_item.levels - bzc_pkg::LVL_W'(1);
		end
	end

	assign in_ready = !valid_q || out_ready;

	// cell valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

### design/bzc_scale.sv
// output stage: scales lane zero by 1, 3 or 6 and holds the result item
module bzc_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bzc_pkg::work_t                      in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bzc_pkg::OUT_W-1:0]    result_x,
	output logic signed [bzc_pkg::OUT_W-1:0]    result_y
);

	logic                              valid_q;
	logic signed [bzc_pkg::OUT_W-1:0]  rx_q;
	logic signed [bzc_pkg::OUT_W-1:0]  ry_q;
	logic signed [bzc_pkg::OUT_W-1:0]  vx;
	logic signed [bzc_pkg::OUT_W-1:0]  vy;
	logic signed [bzc_pkg::OUT_W-1:0]  sx;
	logic signed [bzc_pkg::OUT_W-1:0]  sy;

	// derivative scale by shift and add
	always_comb begin
		vx = bzc_pkg::OUT_W'(in_item.lx[0]);
		vy = bzc_pkg::OUT_W'(in_item.ly[0]);
		unique case (in_item.order)
			bzc_pkg::ORD_POINT: begin
				sx = vx;
				sy = vy;
			end
			bzc_pkg::ORD_FIRST: begin
				sx = (vx <<< 1) + vx;
				sy = (vy <<< 1) + vy;
			end
			bzc_pkg::ORD_SECOND, bzc_pkg::ORD_THIRD: begin
				sx = (vx <<< 2) + (vx <<< 1);
				sy = (vy <<< 2) + (vy <<< 1);
			end
			default: begin
				sx = vx;
				sy = vy;
			end
		endcase
	end

	assign in_ready = !valid_q || out_ready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_q <= sx;
			ry_q <= sy;
		end
	end

	assign out_valid = valid_q;
	assign result_x  = rx_q;
	assign result_y  = ry_q;

endmodule

### design/cubic_bezier_evaluator.sv
// top level of the cubic bezier evaluator: control points, front stage, cells, output
//
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready    | param_t, deriv_order
//  out     | out       | out_valid / out_ready  | result_x, result_y
//
// one item per cycle while out is not stalled; a taken item passes in order through
// the difference stage, three lerp cells and the scale stage, each stage one register deep.
// every stage has its own valid and takes a new item when empty or when it drains,
// so a stall on out only backs up as far as the stages that are full.
// arst_n clears all stage valids and the control points to zero; cfg_ready is always high.
module cubic_bezier_evaluator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bzc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bzc_pkg::COORD_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [bzc_pkg::PARAM_W-1:0]          param_t,
	input  logic [1:0]                           deriv_order,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [bzc_pkg::OUT_W-1:0]     result_x,
	output logic signed [bzc_pkg::OUT_W-1:0]     result_y
);

	bzc_pkg::coords_t px_q;
	bzc_pkg::coords_t py_q;

	logic           v_s1;
	logic           r_s1;
	bzc_pkg::work_t w_s1;
	logic           v_s2;
	logic           r_s2;
	bzc_pkg::work_t w_s2;
	logic           v_s3;
	logic           r_s3;
	bzc_pkg::work_t w_s3;
	logic           v_s4;
	logic           r_s4;
	bzc_pkg::work_t w_s4;

	assign cfg_ready = 1'b1;

	// control point registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bzc_pkg::reg_idx_t'(cfg_index))
				bzc_pkg::REG_P0_X: px_q[0] <= cfg_data;
				bzc_pkg::REG_P0_Y: py_q[0] <= cfg_data;
				bzc_pkg::REG_P1_X: px_q[1] <= cfg_data;
				bzc_pkg::REG_P1_Y: py_q[1] <= cfg_data;
				bzc_pkg::REG_P2_X: px_q[2] <= cfg_data;
				bzc_pkg::REG_P2_Y: py_q[2] <= cfg_data;
				bzc_pkg::REG_P3_X: px_q[3] <= cfg_data;
				bzc_pkg::REG_P3_Y: py_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// difference stage
	bzc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.param_t     (param_t),
		.deriv_order (deriv_order),
		.px          (px_q),
		.py          (py_q),
		.out_valid   (v_s1),
		.out_ready   (r_s1),
		.out_item    (w_s1)
	);

	// three de casteljau cells
	bzc_cell u_cell0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (r_s1),
		.in_item   (w_s1),
		.out_valid (v_s2),
		.out_ready (r_s2),
		.out_item  (w_s2)
	);

	bzc_cell u_cell1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (r_s2),
		.in_item   (w_s2),
		.out_valid (v_s3),
		.out_ready (r_s3),
		.out_item  (w_s3)
	);

	bzc_cell u_cell2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (r_s3),
		.in_item   (w_s3),
		.out_valid (v_s4),
		.out_ready (r_s4),
		.out_item  (w_s4)
	);

	// scaling and output register
	bzc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (r_s4),
		.in_item   (w_s4),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_x  (result_x),
		.result_y  (result_y)
	);

endmodule

### design/bzc_checker.sv
// port-level checks for the cubic bezier evaluator and their binding
`include "assert_macros.svh"

module bzc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [bzc_pkg::OUT_W-1:0]     result_x,
	input logic signed [bzc_pkg::OUT_W-1:0]     result_y
);

	// a waiting result item keeps its value
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(result_x) && $stable(result_y), "result changed while stalled")

	// configuration writes are never refused
	`CHK_SAME(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "cfg_ready dropped")

	// the pipe can only block input when a result is held at the output
	`CHK_SAME(a_in_free, clk, arst_n, !out_valid || out_ready, in_ready,
		"input blocked with output free")

	// with the output drained and no new item, nothing can be left to show
	`CHK_NEXT(a_out_drain, clk, arst_n,
		!in_valid && !out_valid && $past(!in_valid, 1) && $past(!out_valid, 1) &&
		$past(!in_valid, 2) && $past(!in_valid, 3) && $past(!in_valid, 4) &&
		$past(!in_valid, 5),
		!out_valid, "result item without a source item")

endmodule

bind cubic_bezier_evaluator bzc_checker u_bzc_checker (.*);

### tb/sv/bezier_result_checker.sv
// checker for the cubic bezier evaluator: tracks control points, predicts and compares results
`timescale 1ns / 1ps

module bezier_result_checker
	import bzc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [COORD_W-1:0]          cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [PARAM_W-1:0]          param_t,
	input  logic [1:0]                  deriv_order,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic signed [OUT_W-1:0]     result_x,
	input  logic signed [OUT_W-1:0]     result_y,
	output int                          fail_count,
	output int                          pending
);

	localparam int NUM_REGS = 2 * NUM_PTS;
	localparam int REG_SEL_W = $clog2(NUM_REGS);
	localparam longint HALF_LSB = longint'(1) << (FRAC_W - 1);

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
	} curve_pair_t;

	// control points as the block should hold them, x and y interleaved
	coord_t ctrl_pts [0:NUM_REGS-1];

	// expected point or derivative for each item in flight, oldest first
	curve_pair_t curve_results_q [$];

	// one coordinate: forward differences, rounded de casteljau, then order weight
	function automatic logic signed [OUT_W-1:0] curve_coord(longint c0, longint c1,
			longint c2, longint c3, order_t ord, longint t);
		longint v [0:3];
		longint weight;
		int n;
		int i;
		int k;
		v[0] = c0;
		v[1] = c1;
		v[2] = c2;
		v[3] = c3;
		n = NUM_PTS;
		for (k = 0; k < int'(ord); k++) begin
			for (i = 0; i < n - 1; i++)
				v[i] = v[i + 1] - v[i];
			n--;
		end
		while (n > 1) begin
			for (i = 0; i < n - 1; i++)
				v[i] = v[i] + (((v[i + 1] - v[i]) * t + HALF_LSB) >>> FRAC_W);
			n--;
		end
		case (ord)
			ORD_POINT: begin
				weight = 1;
			end
			ORD_FIRST: begin
				weight = 3;
			end
			default: begin
				weight = 6;
			end
		endcase
		return OUT_W'(v[0] * weight);
	endfunction

	// register writes, prediction on input, comparison on output
	always @(posedge clk or negedge arst_n) begin
		curve_pair_t want;
		logic [PARAM_W-1:0] t_sat;
		order_t ord;
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++)
				ctrl_pts[r] <= '0;
		end else begin
			// indexes past the last point register are dropped
			if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_REGS)
				ctrl_pts[cfg_index[REG_SEL_W-1:0]] <= coord_t'(cfg_data);

			if (in_valid && in_ready) begin
				// t above one is clamped to one
				t_sat = (param_t > T_ONE) ? T_ONE : param_t;
				ord = order_t'(deriv_order);
				want.x = curve_coord(longint'(ctrl_pts[REG_P0_X]), longint'(ctrl_pts[REG_P1_X]),
					longint'(ctrl_pts[REG_P2_X]), longint'(ctrl_pts[REG_P3_X]), ord,
					longint'(t_sat));
				want.y = curve_coord(longint'(ctrl_pts[REG_P0_Y]), longint'(ctrl_pts[REG_P1_Y]),
					longint'(ctrl_pts[REG_P2_Y]), longint'(ctrl_pts[REG_P3_Y]), ord,
					longint'(t_sat));
				curve_results_q.push_back(want);
			end

			if (out_valid && out_ready) begin
				if (curve_results_q.size() == 0) begin
					$error("result with no item outstanding: result_x %0d, result_y %0d",
						result_x, result_y);
					fail_count++;
				end else begin
					want = curve_results_q.pop_front();
					if (result_x !== want.x) begin
						$error("result_x: expected %0d, actual %0d", want.x, result_x);
						fail_count++;
					end
					if (result_y !== want.y) begin
						$error("result_y: expected %0d, actual %0d", want.y, result_y);
						fail_count++;
					end
				end
			end
			pending = curve_results_q.size();
		end
	end

endmodule

### tb/sv/cubic_bezier_evaluator_tb.sv
// testbench top for the cubic bezier evaluator: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module cubic_bezier_evaluator_tb;
	import bzc_pkg::*;

	localparam int NUM_REGS         = 2 * NUM_PTS;
	localparam int FIRST_UNUSED_IDX = NUM_REGS;
	localparam int LAST_IDX         = (1 << CFG_IDX_W) - 1;
	localparam int PARAM_MAX        = (1 << PARAM_W) - 1;
	localparam int NUM_PHASES       = 7;
	localparam int ITEMS_PER_PHASE  = 155;
	localparam int SETTLE_CYCLES    = 12;
	localparam int HOLD_AT_ITEM     = 400;
	localparam int HOLD_CYCLES      = 300;
	localparam int WATCHDOG_LIMIT   = 2000;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

	typedef enum int {
		PTS_RANDOM,
		PTS_ALL_MAX,
		PTS_ALL_MIN,
		PTS_ALTERNATE,
		PTS_NEAR_ZERO
	} point_set_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [PARAM_W-1:0] param_t;
	logic [1:0] deriv_order;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] result_x;
	logic signed [OUT_W-1:0] result_y;

	int fail_count;
	int pending;
	int items_sent;
	int burst_left;
	coord_t next_pts [0:NUM_REGS-1];

	cubic_bezier_evaluator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.param_t     (param_t),
		.deriv_order (deriv_order),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_x    (result_x),
		.result_y    (result_y)
	);

	bezier_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.param_t     (param_t),
		.deriv_order (deriv_order),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_x    (result_x),
		.result_y    (result_y),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one register write; valid stays high for a following write
	task automatic write_reg(input int idx, input coord_t value);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// all point registers, then a write to an unused index that must be dropped
	task automatic load_points();
		int r;
		for (r = 0; r < NUM_REGS; r++)
			write_reg(r, next_pts[r]);
		write_reg($urandom_range(FIRST_UNUSED_IDX, LAST_IDX), coord_t'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_points(input point_set_t kind);
		int r;
		for (r = 0; r < NUM_REGS; r++) begin
			case (kind)
				PTS_ALL_MAX: begin
					next_pts[r] = COORD_MAX;
				end
				PTS_ALL_MIN: begin
					next_pts[r] = COORD_MIN;
				end
				PTS_ALTERNATE: begin
					next_pts[r] = ((r / 2) % 2 == 0) ? COORD_MIN : COORD_MAX;
				end
				PTS_NEAR_ZERO: begin
					next_pts[r] = coord_t'($urandom_range(0, 511) - 256);
				end
				default: begin
					next_pts[r] = coord_t'($urandom);
				end
			endcase
		end
	endtask

	// one item, then either the next in the burst or a random gap
	task automatic send_item(input logic [PARAM_W-1:0] t, input order_t ord);
		int gap;
		in_valid <= 1'b1;
		param_t <= t;
		deriv_order <= ord;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap)
					@(negedge clk);
			end
		end
	endtask

	// sender pause: wait for every result, then let the pipe settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// t weighted toward the ends of the range and past one
	function automatic logic [PARAM_W-1:0] pick_t();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return T_ONE;
			2: return PARAM_W'($urandom_range(int'(T_ONE) + 1, PARAM_MAX));
			3: return PARAM_W'($urandom_range(0, 15));
			4: return T_ONE - PARAM_W'($urandom_range(1, 15));
			default: return PARAM_W'($urandom_range(0, int'(T_ONE)));
		endcase
	endfunction

	// receiver: stall pattern refreshed after each pass through its 16 bits, one long hold-off
	initial begin : receiver
		logic [15:0] pattern;
		int phase;
		bit held;
		pattern = '1;
		phase = 0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && items_sent >= HOLD_AT_ITEM) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			out_ready <= pattern[phase];
			phase++;
			if (phase == 16) begin
				phase = 0;
				case ($urandom_range(0, 3))
					0: pattern = '1;
					1: pattern = 16'($urandom);
					2: pattern = 16'($urandom | $urandom);
					default: pattern = 16'($urandom & $urandom);
				endcase
			end
		end
	end

	// watchdog on cycles with no item moving on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[cubic_bezier_evaluator] ERROR");
		$finish;
	end

	// reset, directed items, random phases, verdict
	initial begin : stimulus
		int o;
		int ph;
		int n;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		param_t = '0;
		deriv_order = ORD_POINT;
		items_sent = 0;
		burst_left = 0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// points still at their reset value of zero
		send_item(T_ONE >> 1, ORD_POINT);
		send_item(T_ONE, ORD_THIRD);
		in_valid <= 1'b0;
		wait_drained();

		// opposing extremes give the largest differences in every order
		for (o = 0; o < NUM_REGS; o++)
			next_pts[o] = (o % 4 == 0 || o % 4 == 3) ? COORD_MIN : COORD_MAX;
		load_points();
		@(negedge clk);
		for (o = 0; o <= int'(ORD_THIRD); o++) begin
			send_item('0, order_t'(o));
			send_item(T_ONE, order_t'(o));
			send_item(T_ONE >> 1, order_t'(o));
		end
		send_item(PARAM_W'(1), ORD_POINT);
		send_item(T_ONE - PARAM_W'(1), ORD_POINT);
		send_item(T_ONE + PARAM_W'(1), ORD_FIRST);
		send_item('1, ORD_SECOND);
		in_valid <= 1'b0;
		wait_drained();

		// random items under a new point set per phase
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			fill_points(point_set_t'(ph % 5));
			load_points();
			@(negedge clk);
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(pick_t(), order_t'($urandom_range(0, 3)));
			in_valid <= 1'b0;
			wait_drained();
		end

		if (fail_count == 0 && pending == 0)
			$display("[cubic_bezier_evaluator] OK");
		else
			$display("[cubic_bezier_evaluator] ERROR");
		$finish;
	end

endmodule
